/* hdl/swslp_pkg.sv */
package swslp_pkg;

   localparam int unsigned HOLD_W = 16;
   localparam int unsigned MS_W = 7;
   localparam int unsigned TENTH_W = 4;
   localparam int unsigned SEC_W = 6;
   localparam int unsigned MIN_W = 6;
   localparam int unsigned HOUR_W = 7;

   localparam logic [HOUR_W-1:0] MAX_HOURS = 7'd99;
   localparam logic [MS_W-1:0] TICKS_PER_TENTH = 7'd100;
   localparam logic [MS_W-1:0] LAST_TICK = TICKS_PER_TENTH - 7'd1;
   localparam logic [TENTH_W-1:0] LAST_TENTH = 4'd9;
   localparam logic [SEC_W-1:0] LAST_SECOND = 6'd59;
   localparam logic [MIN_W-1:0] LAST_MINUTE = 6'd59;
   localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;
   localparam logic [HOLD_W-1:0] LONG_PRESS_RESET = 16'd1500;

   // Outcome of one tick of button handling.
   typedef struct packed {
      logic run;
      logic released;
      logic cleared;
   } ctrl_type;

   typedef struct packed {
      logic [HOUR_W-1:0] hours;
      logic [MIN_W-1:0] minutes;
      logic [SEC_W-1:0] seconds;
      logic [TENTH_W-1:0] tenths;
   } time_type;

endpackage

/* hdl/swslp_if.sv */
interface swslp_req_if;
   logic valid;
   logic ready;
   logic button_down;

   modport source (output valid, output button_down, input ready);
   modport sink (input valid, input button_down, output ready);
endinterface

interface swslp_rsp_if;
   logic valid;
   logic ready;
   logic running;
   logic [swslp_pkg::HOUR_W-1:0] hours;
   logic [swslp_pkg::MIN_W-1:0] minutes;
   logic [swslp_pkg::SEC_W-1:0] seconds;
   logic [swslp_pkg::TENTH_W-1:0] tenths;
   logic press_released;
   logic was_reset;

   modport source (output valid, output running, output hours, output minutes,
                   output seconds, output tenths, output press_released,
                   output was_reset, input ready);
   modport sink (input valid, input running, input hours, input minutes,
                 input seconds, input tenths, input press_released,
                 input was_reset, output ready);
endinterface

/* hdl/swslp_press_ctrl.sv */
module swslp_press_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic                         button_down,
   input  logic [swslp_pkg::HOLD_W-1:0] hold_limit,
   output logic                         run_now,
   output swslp_pkg::ctrl_type          ctrl
);

   logic                         run_ff, run_in;
   logic                         held_ff, held_in;
   logic [swslp_pkg::HOLD_W-1:0] hold_count_ff, hold_count_in;

   always_comb begin
      run_in = run_ff;
      held_in = held_ff;
      hold_count_in = hold_count_ff;
      ctrl.released = 1'b0;
      ctrl.cleared = 1'b0;
      if (button_down) begin
         held_in = 1'b1;
         if (!held_ff) begin
            hold_count_in = swslp_pkg::HOLD_W'(1);
         end else if (hold_count_ff != swslp_pkg::HOLD_MAX) begin
            hold_count_in = hold_count_ff + swslp_pkg::HOLD_W'(1);
         end
      end else if (held_ff) begin
         ctrl.released = 1'b1;
         held_in = 1'b0;
         hold_count_in = '0;
         if (hold_count_ff >= hold_limit) begin
            run_in = 1'b0;
            ctrl.cleared = 1'b1;
         end else begin
            run_in = !run_ff;
         end
      end
      ctrl.run = run_in;
   end

   assign run_now = run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         held_ff <= 1'b0;
         hold_count_ff <= '0;
      end else if (fire) begin
         run_ff <= run_in;
         held_ff <= held_in;
         hold_count_ff <= hold_count_in;
      end
   end

endmodule

/* hdl/swslp_time_counter.sv */
module swslp_time_counter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 advance,
   input  logic                 clear,
   output swslp_pkg::time_type  time_next
);

   logic [swslp_pkg::MS_W-1:0]    ms_ff, ms_in;
   logic [swslp_pkg::TENTH_W-1:0] tenth_ff, tenth_in;
   logic [swslp_pkg::SEC_W-1:0]   second_ff, second_in;
   logic [swslp_pkg::MIN_W-1:0]   minute_ff, minute_in;
   logic [swslp_pkg::HOUR_W-1:0]  hour_ff, hour_in;

   // Each stage carries into the next only when it wraps; hours stop at the limit.
   always_comb begin
      ms_in = ms_ff;
      tenth_in = tenth_ff;
      second_in = second_ff;
      minute_in = minute_ff;
      hour_in = hour_ff;
      if (advance) begin
         if (ms_ff < swslp_pkg::LAST_TICK) begin
            ms_in = ms_ff + swslp_pkg::MS_W'(1);
         end else begin
            ms_in = '0;
            if (tenth_ff < swslp_pkg::LAST_TENTH) begin
               tenth_in = tenth_ff + swslp_pkg::TENTH_W'(1);
            end else begin
               tenth_in = '0;
               if (second_ff < swslp_pkg::LAST_SECOND) begin
                  second_in = second_ff + swslp_pkg::SEC_W'(1);
               end else begin
                  second_in = '0;
                  if (minute_ff < swslp_pkg::LAST_MINUTE) begin
                     minute_in = minute_ff + swslp_pkg::MIN_W'(1);
                  end else begin
                     minute_in = '0;
                     if (hour_ff < swslp_pkg::MAX_HOURS) begin
                        hour_in = hour_ff + swslp_pkg::HOUR_W'(1);
                     end
                  end
               end
            end
         end
      end
      if (clear) begin
         ms_in = '0;
         tenth_in = '0;
         second_in = '0;
         minute_in = '0;
         hour_in = '0;
      end
      time_next.hours = hour_in;
      time_next.minutes = minute_in;
      time_next.seconds = second_in;
      time_next.tenths = tenth_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff <= '0;
         tenth_ff <= '0;
         second_ff <= '0;
         minute_ff <= '0;
         hour_ff <= '0;
      end else if (fire) begin
         ms_ff <= ms_in;
         tenth_ff <= tenth_in;
         second_ff <= second_in;
         minute_ff <= minute_in;
         hour_ff <= hour_in;
      end
   end

endmodule

/* hdl/stopwatch_short_long_press_unit.sv */
// The result item for an accepted tick item is registered and appears on rsp_chan in the cycle after it is accepted.
// Throughput: one item per cycle while rsp_chan is ready; the result register refills in the cycle it is taken.
// The counter cascade and the hold compare are combinational between the state
// registers and the result register.
// Reset (synchronous, active high): stopped, time zero, no press pending, no result
// waiting, hold limit back to 1500.
module stopwatch_short_long_press_unit (
   input  logic                         clock,
   input  logic                         reset,
   swslp_req_if.sink                    req_chan,
   swslp_rsp_if.source                  rsp_chan,
   input  logic                         csr_we,
   input  logic [swslp_pkg::HOLD_W-1:0] csr_wdata
);

   logic                         fire;
   logic                         run_now;
   swslp_pkg::ctrl_type          ctrl;
   swslp_pkg::time_type          time_next;
   logic [swslp_pkg::HOLD_W-1:0] long_press_ff;
   logic                         rsp_valid_ff;
   swslp_pkg::ctrl_type          rsp_ctrl_ff;
   swslp_pkg::time_type          rsp_time_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire = req_chan.valid && req_chan.ready;

   swslp_press_ctrl u_press_ctrl (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .button_down (req_chan.button_down),
      .hold_limit  (long_press_ff),
      .run_now     (run_now),
      .ctrl        (ctrl)
   );

   swslp_time_counter u_time_counter (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .advance   (run_now),
      .clear     (ctrl.cleared),
      .time_next (time_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= swslp_pkg::LONG_PRESS_RESET;
      end else if (csr_we) begin
         long_press_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ctrl_ff <= ctrl;
         rsp_time_ff <= time_next;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.running = rsp_ctrl_ff.run;
   assign rsp_chan.hours = rsp_time_ff.hours;
   assign rsp_chan.minutes = rsp_time_ff.minutes;
   assign rsp_chan.seconds = rsp_time_ff.seconds;
   assign rsp_chan.tenths = rsp_time_ff.tenths;
   assign rsp_chan.press_released = rsp_ctrl_ff.released;
   assign rsp_chan.was_reset = rsp_ctrl_ff.cleared;

endmodule

/* dv/stopwatch_short_long_press_unit_tb.sv */
module stopwatch_short_long_press_unit_tb;

   typedef struct packed {
      logic                running;
      swslp_pkg::time_type elapsed;
      logic                released;
      logic                cleared;
   } watch_status_type;

   // Tracks the stopwatch state tick by tick and holds the status items still owed.
   class stopwatch_scoreboard_type;
      logic [swslp_pkg::HOLD_W-1:0] long_limit;
      logic                         run;
      logic                         held;
      logic [swslp_pkg::HOLD_W-1:0] hold_ticks;
      logic [swslp_pkg::MS_W-1:0]   ms_count;
      swslp_pkg::time_type          elapsed;
      watch_status_type             owed_status[$];
      int                           errors;

      function new();
         long_limit = swslp_pkg::LONG_PRESS_RESET;
         run = 1'b0;
         held = 1'b0;
         hold_ticks = '0;
         ms_count = '0;
         elapsed = '0;
         errors = 0;
      endfunction

      function void write_limit(logic [swslp_pkg::HOLD_W-1:0] value);
         long_limit = value;
      endfunction

      function int pending();
         return owed_status.size();
      endfunction

      function void advance_one_ms();
         if (ms_count != swslp_pkg::LAST_TICK) begin
            ms_count++;
            return;
         end
         ms_count = '0;
         if (elapsed.tenths != swslp_pkg::LAST_TENTH) begin
            elapsed.tenths++;
            return;
         end
         elapsed.tenths = '0;
         if (elapsed.seconds != swslp_pkg::LAST_SECOND) begin
            elapsed.seconds++;
            return;
         end
         elapsed.seconds = '0;
         if (elapsed.minutes != swslp_pkg::LAST_MINUTE) begin
            elapsed.minutes++;
            return;
         end
         elapsed.minutes = '0;
         if (elapsed.hours != swslp_pkg::MAX_HOURS) elapsed.hours++;
      endfunction

      function void note_tick(logic down);
         watch_status_type st;
         st.released = 1'b0;
         st.cleared = 1'b0;
         if (run) advance_one_ms();
         if (down) begin
            if (held) begin
               if (hold_ticks != swslp_pkg::HOLD_MAX) hold_ticks++;
            end else begin
               held = 1'b1;
               hold_ticks = swslp_pkg::HOLD_W'(1);
            end
         end else if (held) begin
            st.released = 1'b1;
            if (hold_ticks >= long_limit) begin
               run = 1'b0;
               ms_count = '0;
               elapsed = '0;
               st.cleared = 1'b1;
            end else begin
               run = !run;
            end
            held = 1'b0;
            hold_ticks = '0;
         end
         st.running = run;
         st.elapsed = elapsed;
         owed_status.push_back(st);
      endfunction

      function void check_result(watch_status_type got);
         watch_status_type want;
         if (owed_status.size() == 0) begin
            $error("status item with none expected");
            errors++;
            return;
         end
         want = owed_status.pop_front();
         if (got.running !== want.running) begin
            $error("running: expected %0d, actual %0d", want.running, got.running);
            errors++;
         end
         if (got.elapsed.hours !== want.elapsed.hours) begin
            $error("hours: expected %0d, actual %0d", want.elapsed.hours, got.elapsed.hours);
            errors++;
         end
         if (got.elapsed.minutes !== want.elapsed.minutes) begin
            $error("minutes: expected %0d, actual %0d", want.elapsed.minutes,
                   got.elapsed.minutes);
            errors++;
         end
         if (got.elapsed.seconds !== want.elapsed.seconds) begin
            $error("seconds: expected %0d, actual %0d", want.elapsed.seconds,
                   got.elapsed.seconds);
            errors++;
         end
         if (got.elapsed.tenths !== want.elapsed.tenths) begin
            $error("tenths: expected %0d, actual %0d", want.elapsed.tenths,
                   got.elapsed.tenths);
            errors++;
         end
         if (got.released !== want.released) begin
            $error("press_released: expected %0d, actual %0d", want.released, got.released);
            errors++;
         end
         if (got.cleared !== want.cleared) begin
            $error("was_reset: expected %0d, actual %0d", want.cleared, got.cleared);
            errors++;
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         csr_we;
   logic [swslp_pkg::HOLD_W-1:0] csr_wdata;

   swslp_req_if tick_if();
   swslp_rsp_if status_if();

   stopwatch_short_long_press_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (tick_if.sink),
      .rsp_chan  (status_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   stopwatch_scoreboard_type sb = new();
   bit idling_on;
   int status_hold_off;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("stopwatch_short_long_press_unit_tb: FAIL");
      $finish;
   end

   task automatic send_tick(input logic down);
      int gap;
      gap = idling_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         tick_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      tick_if.valid <= 1'b1;
      tick_if.button_down <= down;
      do @(posedge clock); while (!tick_if.ready);
      sb.note_tick(down);
   endtask

   task automatic send_hold(input logic down, input int count);
      repeat (count) send_tick(down);
   endtask

   task automatic wait_until_idle();
      tick_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_long_limit(input logic [swslp_pkg::HOLD_W-1:0] value);
      wait_until_idle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_limit(value);
   endtask

   // Mostly whole presses, some of them right at the limit, with a little noise between.
   task automatic random_presses(input int count);
      int sent;
      int press_len;
      int burst;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 8);
            repeat (burst) send_tick(1'($urandom_range(0, 1)));
            sent += burst;
         end else begin
            if (sb.long_limit <= 60 && $urandom_range(0, 1) == 1) begin
               press_len = int'(sb.long_limit) - 1 + int'($urandom_range(0, 2));
               if (press_len < 1) press_len = 1;
            end else begin
               press_len = $urandom_range(1, 40);
            end
            burst = $urandom_range(1, 15);
            send_hold(1'b1, press_len);
            send_hold(1'b0, burst);
            sent += press_len + burst;
         end
      end
   endtask

   initial begin
      int stall;
      watch_status_type got;
      status_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (status_hold_off > 0) begin
            stall = status_hold_off;
            status_hold_off = 0;
         end else begin
            stall = idling_on ? $urandom_range(0, 10) : 0;
         end
         if (stall > 0) begin
            status_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         status_if.ready <= 1'b1;
         do @(posedge clock); while (!status_if.valid);
         got.running = status_if.running;
         got.elapsed.hours = status_if.hours;
         got.elapsed.minutes = status_if.minutes;
         got.elapsed.seconds = status_if.seconds;
         got.elapsed.tenths = status_if.tenths;
         got.released = status_if.press_released;
         got.cleared = status_if.was_reset;
         sb.check_result(got);
      end
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      tick_if.valid <= 1'b0;
      tick_if.button_down <= 1'b0;
      idling_on = 1'b1;
      status_hold_off = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Button up with nothing pending, then a short press to start and one to stop.
      send_hold(1'b0, 2);
      send_tick(1'b1);
      send_hold(1'b0, 5);
      send_hold(1'b1, 3);
      send_hold(1'b0, 2);
      // A limit of one or zero turns every release into a clear.
      write_long_limit(16'd1);
      send_tick(1'b1);
      send_tick(1'b0);
      write_long_limit(16'd0);
      send_hold(1'b1, 2);
      send_tick(1'b0);

      // Long holds without idling: the time keeps counting past a tenth of a second while
      // the button stays down.
      write_long_limit(swslp_pkg::HOLD_MAX);
      idling_on = 1'b0;
      send_tick(1'b1);
      send_tick(1'b0);
      send_hold(1'b1, 150);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_hold(1'b1, 100);
      send_hold(1'b0, 3);

      idling_on = 1'b1;
      write_long_limit(16'($urandom_range(2, 12)));
      random_presses(300);
      idling_on = 1'b0;
      write_long_limit(16'd1);
      random_presses(300);
      idling_on = 1'b1;
      write_long_limit(16'($urandom_range(13, 40)));
      random_presses(300);
      write_long_limit(swslp_pkg::LONG_PRESS_RESET);
      random_presses(300);
      // The status side holds off while ticks keep coming, so the input backs up.
      idling_on = 1'b0;
      write_long_limit(16'($urandom_range(2, 30)));
      status_hold_off = 300;
      random_presses(300);

      tick_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("stopwatch_short_long_press_unit_tb: PASS");
      end else begin
         $display("stopwatch_short_long_press_unit_tb: FAIL");
      end
      $finish;
   end
endmodule
